@@ src/rlpe_pkg.sv @@
// Shared types and constants for the RLP item encoder.
package rlpe_pkg;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 64;
   localparam int LENGTH_W = 24;
   localparam int BYTE_W   = 8;
   localparam int MAX_BYTES = 9;
   localparam int COUNT_W  = 4;

   localparam logic [7:0] STR_SHORT = 8'h80;
   localparam logic [7:0] STR_LONG  = 8'hb7;
   localparam logic [7:0] LST_SHORT = 8'hc0;
   localparam logic [7:0] LST_LONG  = 8'hf7;
   localparam logic [7:0] BARE_MAX  = 8'h7f;
   localparam logic [LENGTH_W-1:0] SHORT_MAX = 24'd55;

   typedef enum logic [OP_W-1:0] {
      OP_NUMBER  = 2'd0,
      OP_STRING  = 2'd1,
      OP_PAYLOAD = 2'd2,
      OP_LIST    = 2'd3
   } rlpe_op_type;

   // bytes[0] goes out first
   typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] rlpe_bytes_type;

   typedef struct packed {
      rlpe_bytes_type       bytes;
      logic [COUNT_W-1:0]   count;
   } rlpe_burst_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
   } rlpe_queue_status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] remaining;
      logic               busy;
   } rlpe_back_status_type;

endpackage

@@ src/rlpe_req_if.sv @@
// Request channel interface: one input item per transaction.
interface rlpe_req_if;
   import rlpe_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [VALUE_W-1:0]  value;
   logic [LENGTH_W-1:0] length;
   logic [BYTE_W-1:0]   byte_value;

   modport source (output valid, output operation, output value, output length,
                   output byte_value, input ready);
   modport sink (input valid, input operation, input value, input length,
                 input byte_value, output ready);
endinterface

@@ src/rlpe_rsp_if.sv @@
// Response channel interface: one encoded byte per transaction.
interface rlpe_rsp_if;
   import rlpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

@@ src/rlpe_front.sv @@
// Front end: classifies an input item into a burst of up to nine bytes.
module rlpe_front (
   rlpe_req_if.sink                 req_ch,
   output logic                     push_valid,
   output rlpe_pkg::rlpe_burst_type push_data,
   input  logic                     push_ready
);
   import rlpe_pkg::*;

   function automatic rlpe_burst_type encode_header(
      input logic [LENGTH_W-1:0] len,
      input logic [7:0]          short_base,
      input logic [7:0]          long_base
   );
      rlpe_burst_type b;
      b = '0;
      if (len <= SHORT_MAX) begin
         b.bytes[0] = short_base + len[7:0];
         b.count    = COUNT_W'(1);
      end else if (len[23:8] == '0) begin
         b.bytes[0] = long_base + 8'd1;
         b.bytes[1] = len[7:0];
         b.count    = COUNT_W'(2);
      end else if (len[23:16] == '0) begin
         b.bytes[0] = long_base + 8'd2;
         b.bytes[1] = len[15:8];
         b.bytes[2] = len[7:0];
         b.count    = COUNT_W'(3);
      end else begin
         b.bytes[0] = long_base + 8'd3;
         b.bytes[1] = len[23:16];
         b.bytes[2] = len[15:8];
         b.bytes[3] = len[7:0];
         b.count    = COUNT_W'(4);
      end
      return b;
   endfunction

   logic [COUNT_W-1:0] num_len;
   logic [5:0]         align_shift;
   logic [VALUE_W-1:0] aligned;
   rlpe_burst_type     num_burst;
   rlpe_burst_type     burst;
   logic               drop;

   // Count significant bytes of the number, at least one.
   always_comb begin
      num_len = COUNT_W'(1);
      for (int i = 1; i < 8; i++) begin
         if (req_ch.value[8*i +: 8] != '0) begin
            num_len = COUNT_W'(i + 1);
         end
      end
   end

   assign align_shift = {3'(4'd8 - num_len), 3'b000};
   assign aligned     = req_ch.value << align_shift;

   always_comb begin
      num_burst = '0;
      if (req_ch.value == '0) begin
         num_burst.bytes[0] = STR_SHORT;
         num_burst.count    = COUNT_W'(1);
      end else if (num_len == COUNT_W'(1) && req_ch.value[7:0] <= BARE_MAX) begin
         num_burst.bytes[0] = req_ch.value[7:0];
         num_burst.count    = COUNT_W'(1);
      end else begin
         num_burst.bytes[0] = STR_SHORT + 8'(num_len);
         for (int j = 1; j < MAX_BYTES; j++) begin
            num_burst.bytes[j] = aligned[VALUE_W - 8*j +: 8];
         end
         num_burst.count = num_len + COUNT_W'(1);
      end
   end

   always_comb begin
      burst = '0;
      drop  = 1'b0;
      case (rlpe_op_type'(req_ch.operation))
         OP_NUMBER: begin
            burst = num_burst;
         end
         OP_STRING: begin
            burst = encode_header(req_ch.length, STR_SHORT, STR_LONG);
            // single small byte carries itself in the following payload item
            drop  = (req_ch.length == LENGTH_W'(1)) && (req_ch.byte_value <= BARE_MAX);
         end
         OP_PAYLOAD: begin
            burst.bytes[0] = req_ch.byte_value;
            burst.count    = COUNT_W'(1);
         end
         OP_LIST: begin
            burst = encode_header(req_ch.length, LST_SHORT, LST_LONG);
         end
         default: begin
            burst = '0;
         end
      endcase
   end

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid && !drop;
   assign push_data    = burst;

endmodule

@@ src/rlpe_queue.sv @@
// Two-entry queue of byte bursts between front and back.
module rlpe_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_valid,
   input  rlpe_pkg::rlpe_burst_type        push_data,
   output logic                            push_ready,
   output logic                            pop_valid,
   output rlpe_pkg::rlpe_burst_type        pop_data,
   input  logic                            pop,
   output rlpe_pkg::rlpe_queue_status_type status
);
   import rlpe_pkg::*;

   rlpe_burst_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign status.count = count_ff;
   assign status.full  = !push_ready;

endmodule

@@ src/rlpe_back.sv @@
// Back end: outputs a burst one byte per ready cycle via an output register.
module rlpe_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  rlpe_pkg::rlpe_burst_type       pop_data,
   output logic                           pop,
   rlpe_rsp_if.source                     rsp_ch,
   output rlpe_pkg::rlpe_back_status_type status
);
   import rlpe_pkg::*;

   rlpe_bytes_type     data_ff, data_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      data_in      = data_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (out_free) begin
         if (rem_ff != '0) begin
            // advance within the current burst
            out_valid_in = 1'b1;
            out_byte_in  = data_ff[0];
            out_last_in  = (rem_ff == COUNT_W'(1));
            data_in      = rlpe_bytes_type'(data_ff >> BYTE_W);
            rem_in       = rem_ff - COUNT_W'(1);
         end else if (pop_valid) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_byte_in  = pop_data.bytes[0];
            out_last_in  = (pop_data.count == COUNT_W'(1));
            data_in      = rlpe_bytes_type'(pop_data.bytes >> BYTE_W);
            rem_in       = pop_data.count - COUNT_W'(1);
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.last     = out_last_ff;

   assign status.remaining = rem_ff;
   assign status.busy      = (rem_ff != '0);

endmodule

@@ src/rlp_item_encoder_core.sv @@
// RLP item encoder: requests in, encoded byte stream out.
//
// req_ch carries one item per transaction: an operation (number, string
// header, payload byte, list header) with value, length and byte_value.
// rsp_ch carries one encoded byte per transaction; last marks the final
// byte of an item. A string header of length one whose first byte is
// 0x7f or less produces no bytes at all.
//
// An accepted item is classified at once into a burst of one to nine
// bytes and, unless it produces no bytes, written into a two-entry
// queue. The back end pops a burst from the queue and loads its bytes,
// first byte first, into the output register, one byte per cycle while
// the receiver is ready, so payload bytes and short headers stream at
// one item per cycle; a long number holds the back end for nine bytes.
//
// Reset (synchronous) empties the queue and the output register. When the
// receiver holds rsp_ch.ready low, the output byte holds, the queue fills
// and req_ch.ready drops once both queue entries are taken.
module rlp_item_encoder_core (
   input  logic      clock,
   input  logic      reset,
   rlpe_req_if.sink  req_ch,
   rlpe_rsp_if.source rsp_ch
);
   import rlpe_pkg::*;

   logic                  push_valid;
   logic                  push_ready;
   rlpe_burst_type        push_data;
   logic                  pop_valid;
   rlpe_burst_type        pop_data;
   logic                  pop;
   rlpe_queue_status_type q_status;
   rlpe_back_status_type  b_status;

   rlpe_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   rlpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .status     (q_status)
   );

   rlpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_ch    (rsp_ch),
      .status    (b_status)
   );

   // Bytes left in the back end always sit behind a valid output byte.
   a_busy_has_output: assert property (@(posedge clock) disable iff (reset)
      b_status.busy |-> rsp_ch.valid)
      else $error("back end holds bytes with no output byte presented");

   // A byte without last must be followed by more bytes of the same item.
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last |-> b_status.busy)
      else $error("non-final byte presented with no bytes left");

   // An accepted payload byte is queued on the next cycle.
   a_payload_queued: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.operation == OP_PAYLOAD)
      |=> q_status.count != 2'd0)
      else $error("accepted payload byte missing from queue");

   // Queue never reports more than its two entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count != 2'd3)
      else $error("queue count out of range");

endmodule
